// ----- rtl/ppp_pkg.sv -----
// Shared types and constants for the polyline point projection block.
`default_nettype none
package ppp_pkg;

  // Transaction operation codes.
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_NEAREST = 2'd1,
    OP_GIVEN   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Control sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLS_RD,
    S_CLS_REF,
    S_SRCH,
    S_CLS_DEC,
    S_GATH,
    S_PJ_DIFF,
    S_PJ_MUL,
    S_PJ_SUM,
    S_PJ_CHK,
    S_PJ_DIV,
    S_PJ_FMUL,
    S_PJ_FIN
  } state_t;

  // Segment codes reported with each result.
  localparam logic [1:0] SEG_PREV = 2'd0;
  localparam logic [1:0] SEG_NEXT = 2'd1;
  localparam logic [1:0] SEG_KEY  = 2'd2;

  // Status codes reported with each result.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FEW   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Fraction precision of the segment parameter.
  localparam int FRAC_BITS = 24;
  // Largest squared gap, in squared coordinate units, that still closes the path.
  localparam int CLOSE_LIMIT = 42;
  // Width of a frame number.
  localparam int FRAME_W = 32;

endpackage
`default_nettype wire

// ----- rtl/ppp_key_ram.sv -----
// Keyframe store: one write port and one registered read port.
`default_nettype none
module ppp_key_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 128
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ppp_frac_div.sv -----
// Restoring divider that produces the Q0.24 fraction num / den, one bit a cycle.
`default_nettype none
module ppp_frac_div #(
  parameter int W = 70
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [ppp_pkg::FRAC_BITS-1:0] quot
);

  localparam int CW = $clog2(ppp_pkg::FRAC_BITS + 1);

  logic [W:0]    rem_r;
  logic [W-1:0]  den_r;
  logic [ppp_pkg::FRAC_BITS-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    sh;
  logic          ge;

  // One quotient bit: shift the remainder and subtract when it fits.
  assign sh = {rem_r[W-1:0], 1'b0};
  assign ge = sh >= {1'b0, den_r};

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ppp_pkg::FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? (sh - {1'b0, den_r}) : sh;
      quot_r <= {quot_r[ppp_pkg::FRAC_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// ----- rtl/polyline_point_projection_core.sv -----
// Top level: keyframe store, nearest-key search pipeline and segment projection.
// A keyframe write goes straight to the store and gives no result. A nearest query
// reads the store once for each key in use, then projects onto the segments.
// A given-key query first checks whether the path closes, then projects.
// Throughput: one query at a time; busy is high while a query is in flight.
// Reset: synchronous, active low; clears control and key_count, not the store.
`default_nettype none
module polyline_point_projection_core #(
  parameter int MAX_KEYS   = 256,
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_key_index,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_key_frame,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_key_count,
  output logic             out_valid,
  output logic signed [31:0] out_projected_frame,
  output logic [7:0]       out_chosen_key,
  output logic [1:0]       out_segment_used,
  output logic [1:0]       out_status
);

  localparam int CW    = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int DDW   = CW + 1;
  localparam int LW    = 2 * DDW + 2;
  localparam int DW    = 3 * CW + ppp_pkg::FRAME_W;
  localparam int AW    = $clog2(MAX_KEYS);
  localparam int CNTW  = ($clog2(MAX_KEYS + 1) > 9) ? $clog2(MAX_KEYS + 1) : 9;
  localparam int FXW   = ppp_pkg::FRAME_W + 4;
  localparam int QW    = ppp_pkg::FRAC_BITS + 1;
  localparam int PW    = FXW + QW;
  localparam logic signed [PW-1:0] SAT_HI = PW'(2147483647);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  ppp_pkg::state_t state_r, state_nxt;

  logic            accept;
  logic [8:0]      key_count_r;
  logic [CNTW-1:0] kc_ext, n_cur, key_ext;

  ppp_pkg::op_t    op_r;
  logic [CNTW-1:0] key_r, n_r, cnt_r, near_r;
  logic signed [CW-1:0] px_r, py_r, pz_r;
  logic signed [CW-1:0] refx_r, refy_r, refz_r;

  // Store ports.
  logic            ram_we;
  logic [DW-1:0]   ram_wdata, ram_rdata;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic signed [CW-1:0] rd_x, rd_y, rd_z;

  // Search pipeline.
  logic            launch;
  logic [CNTW-1:0] launch_last, last_r;
  logic            iss_act_r;
  logic [CNTW-1:0] iss_cnt_r, idx1_r, idx2_r, idx3_r;
  logic            v1_r, v2_r, v3_r;
  logic signed [DDW-1:0] dx_r, dy_r, dz_r;
  logic [2*DDW-1:0] sqx_r, sqy_r, sqz_r;
  logic [LW-1:0]   dist_sum, best_r;
  logic            srch_done;

  // Closure decision.
  logic [CNTW-1:0] cls_cnt;

  // Gather of the keys around the chosen one.
  logic [2:0]      gcnt_r;
  logic [CNTW-1:0] prev_idx, next_idx, gaddr;
  logic [DW-1:0]   gw_r [5];
  logic signed [CW-1:0] gx [5];
  logic signed [CW-1:0] gy [5];
  logic signed [CW-1:0] gz [5];
  logic signed [ppp_pkg::FRAME_W-1:0] gf [5];

  // Projection datapath.
  logic [1:0]      seg_r;
  logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  logic signed [FXW-1:0] period, fp, fk, fn, f0_sel, f1_sel;
  logic signed [DDW-1:0] sx_r, sy_r, sz_r, rx_r, ry_r, rz_r;
  logic signed [FXW-1:0] f0_r, fd_r;
  logic signed [2*DDW-1:0] msx_r, msy_r, msz_r, mrx_r, mry_r, mrz_r;
  logic signed [LW-1:0] dot_r, len_r;
  logic            pj_fail;
  logic            div_start, div_done;
  logic [ppp_pkg::FRAC_BITS-1:0] div_quot;
  logic signed [QW-1:0] q_ext;
  logic signed [PW-1:0] prod_r, res_full, res_sat;

  // Result registers.
  logic            emit;
  logic signed [31:0] emit_frame;
  logic [7:0]      emit_key;
  logic [1:0]      emit_seg, emit_status;
  logic            out_valid_r;
  logic signed [31:0] out_frame_r;
  logic [7:0]      out_key_r;
  logic [1:0]      out_seg_r, out_status_r;

  assign busy   = (state_r != ppp_pkg::S_IDLE);
  assign accept = start && !busy;

  assign kc_ext  = CNTW'(key_count_r);
  assign n_cur   = (kc_ext > CNTW'(MAX_KEYS)) ? CNTW'(MAX_KEYS) : kc_ext;
  assign key_ext = CNTW'(in_key_index);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_we) begin
      key_count_r <= cfg_key_count;
    end
  end

  // Keyframe writes go straight to the store when the transaction is accepted.
  assign ram_we    = accept && (ppp_pkg::op_t'(in_operation) == ppp_pkg::OP_WRITE)
                     && (key_ext < CNTW'(MAX_KEYS));
  assign ram_wdata = {in_key_frame, in_pos_z[CW-1:0], in_pos_y[CW-1:0], in_pos_x[CW-1:0]};

  ppp_key_ram #(
    .DEPTH (MAX_KEYS),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_ext[AW-1:0]),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[CW-1:0];
  assign rd_y = ram_rdata[2*CW-1:CW];
  assign rd_z = ram_rdata[3*CW-1:2*CW];

  // Query capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= ppp_pkg::op_t'(in_operation);
      key_r <= key_ext;
      n_r   <= n_cur;
      px_r  <= in_pos_x[CW-1:0];
      py_r  <= in_pos_y[CW-1:0];
      pz_r  <= in_pos_z[CW-1:0];
    end
  end

  // Reference point of the distance pipeline: the query, or the last key.
  always_ff @(posedge clk) begin
    if (accept) begin
      refx_r <= in_pos_x[CW-1:0];
      refy_r <= in_pos_y[CW-1:0];
      refz_r <= in_pos_z[CW-1:0];
    end else if (state_r == ppp_pkg::S_CLS_REF) begin
      refx_r <= rd_x;
      refy_r <= rd_y;
      refz_r <= rd_z;
    end
  end

  // Search pipeline control: issue, then three stages of valid tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
    end else begin
      if (launch) begin
        iss_act_r <= 1'b1;
      end else if (iss_act_r && (iss_cnt_r == last_r)) begin
        iss_act_r <= 1'b0;
      end
      v1_r <= iss_act_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Search pipeline datapath: read, difference, square, sum and compare.
  always_ff @(posedge clk) begin
    if (launch) begin
      iss_cnt_r <= '0;
      last_r    <= launch_last;
    end else if (iss_act_r) begin
      iss_cnt_r <= iss_cnt_r + CNTW'(1);
    end
    idx1_r <= iss_cnt_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    dx_r   <= DDW'(rd_x) - DDW'(refx_r);
    dy_r   <= DDW'(rd_y) - DDW'(refy_r);
    dz_r   <= DDW'(rd_z) - DDW'(refz_r);
    sqx_r  <= dx_r * dx_r;
    sqy_r  <= dy_r * dy_r;
    sqz_r  <= dz_r * dz_r;
  end

  assign dist_sum  = LW'(sqx_r) + LW'(sqy_r) + LW'(sqz_r);
  assign srch_done = v3_r && (idx3_r == last_r);

  // Running minimum; the first minimum wins. A given key replaces it later.
  always_ff @(posedge clk) begin
    if (v3_r && ((idx3_r == '0) || (dist_sum < best_r))) begin
      best_r <= dist_sum;
      near_r <= idx3_r;
    end else if (state_r == ppp_pkg::S_CLS_DEC) begin
      near_r <= key_r;
    end
  end

  assign cls_cnt = (best_r <= LW'(ppp_pkg::CLOSE_LIMIT)) ? (n_r - CNTW'(1)) : n_r;

  // Key count used for wrapping.
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r <= n_cur;
    end else if (state_r == ppp_pkg::S_CLS_DEC) begin
      cnt_r <= cls_cnt;
    end
  end

  // Neighbors of the chosen key, wrapping within the key count.
  assign prev_idx = (near_r == '0) ? (cnt_r - CNTW'(1)) : (near_r - CNTW'(1));
  assign next_idx = ((near_r + CNTW'(1)) == cnt_r) ? '0 : (near_r + CNTW'(1));

  // Gather order: first key, last key, previous, chosen, next.
  always_comb begin
    unique case (gcnt_r)
      3'd0:    gaddr = '0;
      3'd1:    gaddr = n_r - CNTW'(1);
      3'd2:    gaddr = prev_idx;
      3'd3:    gaddr = near_r;
      3'd4:    gaddr = next_idx;
      default: gaddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r <= '0;
    end else begin
      gcnt_r <= (state_r == ppp_pkg::S_GATH) ? (gcnt_r + 3'd1) : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ppp_pkg::S_GATH) && (gcnt_r != 3'd0) && (gcnt_r <= 3'd5)) begin
      gw_r[gcnt_r - 3'd1] <= ram_rdata;
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      gx[i] = gw_r[i][CW-1:0];
      gy[i] = gw_r[i][2*CW-1:CW];
      gz[i] = gw_r[i][3*CW-1:2*CW];
      gf[i] = gw_r[i][DW-1:3*CW];
    end
  end

  // Segment ends and their frames; segments across key 0 shift by the period.
  assign period = FXW'(gf[1]) - FXW'(gf[0]);
  assign fk     = FXW'(gf[3]);
  assign fp     = FXW'(gf[2]) - ((near_r == '0) ? period : '0);
  assign fn     = FXW'(gf[4]) + ((next_idx == '0) ? period : '0);

  assign ax     = (seg_r == ppp_pkg::SEG_PREV) ? gx[2] : gx[3];
  assign ay     = (seg_r == ppp_pkg::SEG_PREV) ? gy[2] : gy[3];
  assign az     = (seg_r == ppp_pkg::SEG_PREV) ? gz[2] : gz[3];
  assign bx     = (seg_r == ppp_pkg::SEG_PREV) ? gx[3] : gx[4];
  assign by     = (seg_r == ppp_pkg::SEG_PREV) ? gy[3] : gy[4];
  assign bz     = (seg_r == ppp_pkg::SEG_PREV) ? gz[3] : gz[4];
  assign f0_sel = (seg_r == ppp_pkg::SEG_PREV) ? fp : fk;
  assign f1_sel = (seg_r == ppp_pkg::SEG_PREV) ? fk : fn;

  // Segment under test: previous first, then next.
  always_ff @(posedge clk) begin
    if (state_r == ppp_pkg::S_GATH) begin
      seg_r <= ppp_pkg::SEG_PREV;
    end else if ((state_r == ppp_pkg::S_PJ_CHK) && pj_fail) begin
      seg_r <= ppp_pkg::SEG_NEXT;
    end
  end

  // Projection stages: differences, products, sums, frame product.
  always_ff @(posedge clk) begin
    if (state_r == ppp_pkg::S_PJ_DIFF) begin
      sx_r <= DDW'(bx) - DDW'(ax);
      sy_r <= DDW'(by) - DDW'(ay);
      sz_r <= DDW'(bz) - DDW'(az);
      rx_r <= DDW'(px_r) - DDW'(ax);
      ry_r <= DDW'(py_r) - DDW'(ay);
      rz_r <= DDW'(pz_r) - DDW'(az);
      f0_r <= f0_sel;
      fd_r <= f1_sel - f0_sel;
    end
    if (state_r == ppp_pkg::S_PJ_MUL) begin
      msx_r <= sx_r * sx_r;
      msy_r <= sy_r * sy_r;
      msz_r <= sz_r * sz_r;
      mrx_r <= sx_r * rx_r;
      mry_r <= sy_r * ry_r;
      mrz_r <= sz_r * rz_r;
    end
    if (state_r == ppp_pkg::S_PJ_SUM) begin
      dot_r <= LW'(mrx_r) + LW'(mry_r) + LW'(mrz_r);
      len_r <= LW'(msx_r) + LW'(msy_r) + LW'(msz_r);
    end
    if (state_r == ppp_pkg::S_PJ_FMUL) begin
      prod_r <= fd_r * q_ext;
    end
  end

  assign pj_fail = (len_r == '0) || (dot_r < 0) || (dot_r >= len_r);

  ppp_frac_div #(
    .W (LW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ($unsigned(dot_r)),
    .den   ($unsigned(len_r)),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_ext    = {1'b0, div_quot};
  assign res_full = PW'(f0_r) + (prod_r >>> ppp_pkg::FRAC_BITS);
  assign res_sat  = (res_full > SAT_HI) ? SAT_HI : ((res_full < SAT_LO) ? SAT_LO : res_full);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: next state, store reads, search launch, divider start and result loading.
  always_comb begin
    state_nxt   = state_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    launch      = 1'b0;
    launch_last = '0;
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_frame  = '0;
    emit_key    = '0;
    emit_seg    = ppp_pkg::SEG_PREV;
    emit_status = ppp_pkg::STAT_OK;
    unique case (state_r)
      ppp_pkg::S_IDLE: begin
        if (accept) begin
          unique case (ppp_pkg::op_t'(in_operation))
            ppp_pkg::OP_NEAREST: begin
              if (n_cur < CNTW'(2)) begin
                emit        = 1'b1;
                emit_status = ppp_pkg::STAT_FEW;
              end else begin
                launch      = 1'b1;
                launch_last = n_cur - CNTW'(1);
                state_nxt   = ppp_pkg::S_SRCH;
              end
            end
            ppp_pkg::OP_GIVEN: begin
              if (n_cur < CNTW'(2)) begin
                emit        = 1'b1;
                emit_status = ppp_pkg::STAT_FEW;
              end else begin
                state_nxt = ppp_pkg::S_CLS_RD;
              end
            end
            ppp_pkg::OP_WRITE, ppp_pkg::OP_NONE: begin
              state_nxt = ppp_pkg::S_IDLE;
            end
          endcase
        end
      end
      ppp_pkg::S_CLS_RD: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(n_r - CNTW'(1));
        state_nxt = ppp_pkg::S_CLS_REF;
      end
      ppp_pkg::S_CLS_REF: begin
        launch      = 1'b1;
        launch_last = '0;
        state_nxt   = ppp_pkg::S_SRCH;
      end
      ppp_pkg::S_SRCH: begin
        rd_en   = iss_act_r;
        rd_addr = iss_cnt_r[AW-1:0];
        if (srch_done) begin
          state_nxt = (op_r == ppp_pkg::OP_NEAREST) ? ppp_pkg::S_GATH : ppp_pkg::S_CLS_DEC;
        end
      end
      ppp_pkg::S_CLS_DEC: begin
        if (cls_cnt < CNTW'(2)) begin
          emit        = 1'b1;
          emit_status = ppp_pkg::STAT_FEW;
          state_nxt   = ppp_pkg::S_IDLE;
        end else if (key_r >= cls_cnt) begin
          emit        = 1'b1;
          emit_status = ppp_pkg::STAT_RANGE;
          state_nxt   = ppp_pkg::S_IDLE;
        end else begin
          state_nxt = ppp_pkg::S_GATH;
        end
      end
      ppp_pkg::S_GATH: begin
        if (gcnt_r < 3'd5) begin
          rd_en   = 1'b1;
          rd_addr = gaddr[AW-1:0];
        end else begin
          state_nxt = ppp_pkg::S_PJ_DIFF;
        end
      end
      ppp_pkg::S_PJ_DIFF: state_nxt = ppp_pkg::S_PJ_MUL;
      ppp_pkg::S_PJ_MUL:  state_nxt = ppp_pkg::S_PJ_SUM;
      ppp_pkg::S_PJ_SUM:  state_nxt = ppp_pkg::S_PJ_CHK;
      ppp_pkg::S_PJ_CHK: begin
        if (!pj_fail) begin
          div_start = 1'b1;
          state_nxt = ppp_pkg::S_PJ_DIV;
        end else if (seg_r == ppp_pkg::SEG_PREV) begin
          state_nxt = ppp_pkg::S_PJ_DIFF;
        end else begin
          emit       = 1'b1;
          emit_frame = fk[31:0];
          emit_key   = near_r[7:0];
          emit_seg   = ppp_pkg::SEG_KEY;
          state_nxt  = ppp_pkg::S_IDLE;
        end
      end
      ppp_pkg::S_PJ_DIV: begin
        if (div_done) begin
          state_nxt = ppp_pkg::S_PJ_FMUL;
        end
      end
      ppp_pkg::S_PJ_FMUL: state_nxt = ppp_pkg::S_PJ_FIN;
      ppp_pkg::S_PJ_FIN: begin
        emit       = 1'b1;
        emit_frame = res_sat[31:0];
        emit_key   = near_r[7:0];
        emit_seg   = seg_r;
        state_nxt  = ppp_pkg::S_IDLE;
      end
      default: state_nxt = ppp_pkg::S_IDLE;
    endcase
  end

  // Result registers: each result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_frame_r  <= emit_frame;
      out_key_r    <= emit_key;
      out_seg_r    <= emit_seg;
      out_status_r <= emit_status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_projected_frame = out_frame_r;
  assign out_chosen_key      = out_key_r;
  assign out_segment_used    = out_seg_r;
  assign out_status          = out_status_r;

`ifndef SYNTHESIS
  // A successful result only comes out of a query that was in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ppp_pkg::STAT_OK) |-> $past(busy))
    else $error("ok result without a query in flight");

  // Error results carry zero payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ppp_pkg::STAT_OK) |->
      (out_projected_frame == '0) && (out_chosen_key == '0) &&
      (out_segment_used == ppp_pkg::SEG_PREV))
    else $error("error result with nonzero payload");

  // The frame product is only formed once the divider has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppp_pkg::S_PJ_FMUL) |-> $past(div_done))
    else $error("frame product formed before the fraction was ready");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_polyline_point_projection_core.sv -----
// Self-checking testbench for the polyline point projection core.
`timescale 1ns / 100ps
`default_nettype none
module tb_polyline_point_projection_core;

  localparam int KEY_SLOTS = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [31:0] frame;
    logic [7:0]         key;
    logic [1:0]         seg;
    logic [1:0]         status;
  } proj_result_t;

  // Scoreboard: mirrors the keyframe store and predicts each query answer.
  class projection_scoreboard;
    logic signed [31:0] x_store[KEY_SLOTS];
    logic signed [31:0] y_store[KEY_SLOTS];
    logic signed [31:0] z_store[KEY_SLOTS];
    logic signed [31:0] f_store[KEY_SLOTS];
    int unsigned key_count;
    proj_result_t pending[$];
    int errors;
    int results_seen;
    int queries_seen;
    int seg_hits[3];
    int status_hits[3];

    function new();
      key_count = 0;
      errors = 0;
      results_seen = 0;
      queries_seen = 0;
      foreach (seg_hits[i]) seg_hits[i] = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_key_count(int unsigned v);
      key_count = v;
    endfunction

    // Squared distance from stored key k to a point, exact.
    function logic [127:0] sq_gap(int k, logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z);
      logic signed [127:0] dx, dy, dz;
      dx = x_store[k];
      dy = y_store[k];
      dz = z_store[k];
      dx = dx - x;
      dy = dy - y;
      dz = dz - z;
      return dx * dx + dy * dy + dz * dz;
    endfunction

    // Projects the point onto segment a->b and interpolates the frame.
    function bit seg_project(int a, int b, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, longint f0, longint f1,
                             output longint res);
      logic signed [127:0] sv[3], rv[3], dot, len, frac;
      sv[0] = x_store[b]; sv[0] = sv[0] - x_store[a];
      sv[1] = y_store[b]; sv[1] = sv[1] - y_store[a];
      sv[2] = z_store[b]; sv[2] = sv[2] - z_store[a];
      rv[0] = x; rv[0] = rv[0] - x_store[a];
      rv[1] = y; rv[1] = rv[1] - y_store[a];
      rv[2] = z; rv[2] = rv[2] - z_store[a];
      dot = sv[0] * rv[0] + sv[1] * rv[1] + sv[2] * rv[2];
      len = sv[0] * sv[0] + sv[1] * sv[1] + sv[2] * sv[2];
      res = 0;
      if (len == 0 || dot < 0 || dot >= len) return 0;
      frac = (dot <<< ppp_pkg::FRAC_BITS) / len;
      res = f0 + (((f1 - f0) * longint'(frac[31:0])) >>> ppp_pkg::FRAC_BITS);
      return 1;
    endfunction

    // Notes one accepted transaction and queues its predicted answer, if any.
    function void note_input(ppp_pkg::op_t op, logic [7:0] key, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z,
                             logic signed [31:0] f);
      proj_result_t r;
      int n, cnt, near, prv, nxt;
      longint period, fp, fk, fn, res;
      logic [127:0] best, d;
      if (op == ppp_pkg::OP_WRITE) begin
        x_store[key] = x;
        y_store[key] = y;
        z_store[key] = z;
        f_store[key] = f;
        return;
      end
      if (op == ppp_pkg::OP_NONE) return;
      queries_seen++;
      n = (key_count > KEY_SLOTS) ? KEY_SLOTS : key_count;
      r.frame = 0;
      r.key = 0;
      r.seg = ppp_pkg::SEG_PREV;
      r.status = ppp_pkg::STAT_OK;
      cnt = n;
      near = 0;
      if (n < 2) begin
        r.status = ppp_pkg::STAT_FEW;
      end else if (op == ppp_pkg::OP_NEAREST) begin
        best = 0;
        for (int i = 0; i < n; i++) begin
          d = sq_gap(i, x, y, z);
          if (i == 0 || d < best) begin
            best = d;
            near = i;
          end
        end
      end else begin
        // A path whose ends nearly coincide drops its last key from projection.
        d = sq_gap(0, x_store[n - 1], y_store[n - 1], z_store[n - 1]);
        cnt = (d <= ppp_pkg::CLOSE_LIMIT) ? n - 1 : n;
        if (cnt < 2) r.status = ppp_pkg::STAT_FEW;
        else if (key >= cnt) r.status = ppp_pkg::STAT_RANGE;
        near = key;
      end
      if (r.status == ppp_pkg::STAT_OK) begin
        prv = (near == 0) ? cnt - 1 : near - 1;
        nxt = (near + 1 == cnt) ? 0 : near + 1;
        period = longint'(f_store[n - 1]) - longint'(f_store[0]);
        fp = f_store[prv];
        fk = f_store[near];
        fn = f_store[nxt];
        if (near == 0) fp -= period;
        if (nxt == 0) fn += period;
        if (seg_project(prv, near, x, y, z, fp, fk, res)) r.seg = ppp_pkg::SEG_PREV;
        else if (seg_project(near, nxt, x, y, z, fk, fn, res)) r.seg = ppp_pkg::SEG_NEXT;
        else begin
          res = fk;
          r.seg = ppp_pkg::SEG_KEY;
        end
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        r.frame = res[31:0];
        r.key = near[7:0];
        seg_hits[r.seg]++;
      end
      status_hits[r.status]++;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compares one result transaction against the oldest prediction.
    task check_result(logic signed [31:0] frame, logic [7:0] key, logic [1:0] seg,
                      logic [1:0] status);
      proj_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result frame=%h key=%0d", frame, key));
        return;
      end
      e = pending.pop_front();
      if (status !== e.status)
        report($sformatf("status got %0d want %0d", status, e.status));
      if (frame !== e.frame)
        report($sformatf("frame got %h want %h", frame, e.frame));
      if (key !== e.key)
        report($sformatf("chosen key got %0d want %0d", key, e.key));
      if (seg !== e.seg)
        report($sformatf("segment got %0d want %0d", seg, e.seg));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = ppp_pkg::OP_NONE;
  logic [7:0] in_key_index = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic signed [31:0] in_key_frame = '0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_key_count = '0;
  logic out_valid;
  logic signed [31:0] out_projected_frame;
  logic [7:0] out_chosen_key;
  logic [1:0] out_segment_used;
  logic [1:0] out_status;

  projection_scoreboard sb;
  int items_sent = 0;
  int idle_cycles = 0;
  int gap_percent = 24;
  bit written[KEY_SLOTS];

  always #6 clk = ~clk;

  polyline_point_projection_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key_index(in_key_index),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_key_frame(in_key_frame),
    .cfg_we(cfg_we), .cfg_key_count(cfg_key_count),
    .out_valid(out_valid), .out_projected_frame(out_projected_frame),
    .out_chosen_key(out_chosen_key), .out_segment_used(out_segment_used),
    .out_status(out_status)
  );

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && sb != null)
      sb.check_result(out_projected_frame, out_chosen_key, out_segment_used, out_status);
  end

  // Watchdog: fails the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Presents one transaction and holds it until the block takes it.
  task send_item(ppp_pkg::op_t op, logic [7:0] key, logic signed [31:0] x,
                 logic signed [31:0] y, logic signed [31:0] z, logic signed [31:0] f);
    int gap;
    start <= 1'b1;
    in_operation <= op;
    in_key_index <= key;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_key_frame <= f;
    do @(posedge clk); while (busy);
    sb.note_input(op, key, x, y, z, f);
    if (op == ppp_pkg::OP_WRITE) written[key] = 1'b1;
    if (op != ppp_pkg::OP_NONE) items_sent++;
    if ($urandom_range(99) < gap_percent) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes key_count once the block has gone quiet.
  task set_key_count(int unsigned v);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_key_count <= v[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_key_count(v);
  endtask

  function automatic logic signed [31:0] rand_coord(int scale);
    case ($urandom_range(9))
      0: return $urandom;
      1: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(2 * scale)) - scale;
    endcase
  endfunction

  // Fills keys 0..n-1 with a looping path, sometimes closed, with repeats.
  task write_path(int n);
    logic signed [31:0] x, y, z, f;
    int scale, stepf;
    bit closed;
    scale = ($urandom_range(3) == 0) ? 32'h3fffffff : $urandom_range(4096, 1 << 22);
    closed = ($urandom_range(2) == 0);
    stepf = $urandom_range(1, 1 << 20);
    f = $signed($urandom_range(1 << 24)) - (1 << 23);
    x = rand_coord(scale);
    y = rand_coord(scale);
    z = rand_coord(scale);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1 && closed) begin
        x = sb.x_store[0] + $signed($urandom_range(0, 7));
        y = sb.y_store[0];
        z = sb.z_store[0];
      end else if (k > 0 && $urandom_range(9) != 0) begin
        x = x + $signed($urandom_range(scale / 4)) - scale / 8;
        y = y + $signed($urandom_range(scale / 4)) - scale / 8;
        z = ($urandom_range(1)) ? z : z + $signed($urandom_range(scale / 8)) - scale / 16;
      end else if (k > 0 && $urandom_range(1) == 0) begin
        x = rand_coord(scale);
        y = rand_coord(scale);
        z = rand_coord(scale);
      end
      f = ($urandom_range(15) == 0) ? $signed($urandom) : f + stepf;
      send_item(ppp_pkg::OP_WRITE, k[7:0], x, y, z, f);
    end
  endtask

  // One query: near a key, between two keys, or anywhere.
  task send_query(int n);
    logic signed [31:0] x, y, z;
    int k, j, sel;
    ppp_pkg::op_t op;
    logic [7:0] key;
    k = (n > 0) ? $urandom_range(((n > KEY_SLOTS) ? KEY_SLOTS : n) - 1) : 0;
    j = (n > 0) ? $urandom_range(((n > KEY_SLOTS) ? KEY_SLOTS : n) - 1) : 0;
    sel = $urandom_range(99);
    if (sel < 50 && written[k]) begin
      x = sb.x_store[k] + $signed($urandom_range(2000)) - 1000;
      y = sb.y_store[k] + $signed($urandom_range(2000)) - 1000;
      z = sb.z_store[k] + $signed($urandom_range(200)) - 100;
    end else if (sel < 80 && written[k] && written[j]) begin
      x = 32'((longint'(sb.x_store[k]) + sb.x_store[j]) >>> 1);
      y = 32'((longint'(sb.y_store[k]) + sb.y_store[j]) >>> 1);
      z = 32'((longint'(sb.z_store[k]) + sb.z_store[j]) >>> 1);
    end else begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end
    op = ($urandom_range(1)) ? ppp_pkg::OP_NEAREST : ppp_pkg::OP_GIVEN;
    key = ($urandom_range(7) == 0) ? 8'($urandom) : k[7:0];
    send_item(op, key, x, y, z, $urandom);
  endtask

  initial begin
    int plan[$];
    int n, nq;
    sb = new();
    foreach (written[i]) written[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no keys, ignored operation, then extremes on tiny paths.
    send_item(ppp_pkg::OP_NEAREST, 8'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    send_item(ppp_pkg::OP_GIVEN, 8'd255, 32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh0);
    send_item(ppp_pkg::OP_NONE, 8'hff, 32'shffffffff, 32'shffffffff, 32'shffffffff,
              32'shffffffff);
    send_item(ppp_pkg::OP_WRITE, 8'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff);
    send_item(ppp_pkg::OP_WRITE, 8'd1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000);
    send_item(ppp_pkg::OP_WRITE, 8'd2, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    set_key_count(1);
    send_item(ppp_pkg::OP_NEAREST, 8'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    set_key_count(3);
    // Big coordinates and opposed end frames drive the frame into saturation.
    send_item(ppp_pkg::OP_NEAREST, 8'd0, 32'sh7fff0000, 32'sh7fff0000, 32'sh7fff0000, 32'sh0);
    send_item(ppp_pkg::OP_NEAREST, 8'd0, 32'sh80010000, 32'sh80010000, 32'sh80010000, 32'sh0);
    send_item(ppp_pkg::OP_GIVEN, 8'd0, 32'sh40000000, 32'sh40000000, 32'sh40000000, 32'sh0);
    send_item(ppp_pkg::OP_GIVEN, 8'd1, 32'shc0000000, 32'shc0000000, 32'shc0000000, 32'sh0);
    send_item(ppp_pkg::OP_GIVEN, 8'd2, 32'sh1, 32'sh1, 32'sh1, 32'sh0);
    send_item(ppp_pkg::OP_GIVEN, 8'd3, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    // Closed two-key path leaves one projectable key; repeated keys give zero length.
    send_item(ppp_pkg::OP_WRITE, 8'd1, 32'sh80000006, 32'sh80000000, 32'sh80000000,
              32'sh10000);
    set_key_count(2);
    send_item(ppp_pkg::OP_GIVEN, 8'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    send_item(ppp_pkg::OP_NEAREST, 8'd1, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    send_item(ppp_pkg::OP_WRITE, 8'd1, 32'sh80000007, 32'sh80000000, 32'sh80000000,
              32'sh10000);
    send_item(ppp_pkg::OP_GIVEN, 8'd1, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    send_item(ppp_pkg::OP_GIVEN, 8'd2, 32'sh0, 32'sh0, 32'sh0, 32'sh0);

    // Random phases over a spread of key counts, the extremes among them.
    plan = '{3, 4, 256, 2, 5, 8, 511, 0, 16, 3, 6, 300, 12, 4, 7};
    while (items_sent < 600) begin
      if (items_sent >= 400) gap_percent = 0;
      else if (items_sent >= 200) gap_percent = 80;
      n = (plan.size() != 0) ? plan.pop_front() : $urandom_range(2, 20);
      set_key_count(n);
      if (n >= 2) write_path((n > KEY_SLOTS) ? KEY_SLOTS : n);
      nq = (n > 64) ? 6 : $urandom_range(15, 40);
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(9) == 0) begin
          send_item(ppp_pkg::OP_NONE, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else if ($urandom_range(11) == 0 && n >= 2) begin
          // Rewriting a key in use reshapes the path mid-phase.
          n = (n > KEY_SLOTS) ? KEY_SLOTS : n;
          send_item(ppp_pkg::OP_WRITE, 8'($urandom_range(n - 1)), rand_coord(1 << 20),
                    rand_coord(1 << 20), rand_coord(1 << 20), $urandom);
        end else begin
          send_query(n);
        end
      end
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transactions, %0d queries, %0d results checked",
             items_sent, sb.queries_seen, sb.results_seen);
    $display("segments prev/next/key %0d/%0d/%0d, status ok/few/range %0d/%0d/%0d",
             sb.seg_hits[0], sb.seg_hits[1], sb.seg_hits[2],
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/ppp_pkg.sv
rtl/ppp_key_ram.sv
rtl/ppp_frac_div.sv
rtl/polyline_point_projection_core.sv
sim/tb_polyline_point_projection_core.sv
